// File: hdl/arlz_pkg.sv
// Shared types, codes and constants of the adaptive range LZ decompressor.
`default_nettype none
package arlz_pkg;

  localparam int unsigned NUM_PROBS   = 385;
  localparam int unsigned CODER_W     = 20;
  localparam int unsigned CTX_W       = 9;
  localparam logic [8:0]  CTX_FLAG    = 9'd0;
  localparam logic [8:0]  CTX_REP     = 9'd256;
  localparam logic [8:0]  CTX_OFFSET  = 9'd257;
  localparam logic [8:0]  CTX_LENGTH  = 9'd321;
  localparam logic [7:0]  PROB_INIT   = 8'd128;

  localparam logic [2:0] STS_NEED     = 3'd0;
  localparam logic [2:0] STS_MORE     = 3'd1;
  localparam logic [2:0] STS_FINISHED = 3'd2;
  localparam logic [2:0] STS_ERROR    = 3'd3;
  localparam logic [2:0] STS_REJECTED = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_FLAG     = 3'd0,
    PH_REP      = 3'd1,
    PH_LIT      = 3'd2,
    PH_OFS_FLAG = 3'd3,
    PH_OFS_BIT  = 3'd4,
    PH_LEN_FLAG = 3'd5,
    PH_LEN_BIT  = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_BIT_RD,
    ST_BIT_EX,
    ST_CP_RD,
    ST_CP_EX,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
    logic n_clr;
    logic reject;
    logic bit_rd;
    logic bit_ex;
    logic cp_rd;
    logic cp_ex;
    logic fin;
    logic out_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [2:0] st_code;
    logic       stop;
    logic       copy_pend;
    logic       coder_ge;
    logic       out_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/arlz_dp.sv
// Datapath: range coder, probability and window memories, burst buffer, output register.
`default_nettype none
module arlz_dp #(
  parameter int WINDOW_LOG2 = 15,
  parameter int MAX_BURST   = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_byte,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  input  wire arlz_pkg::dp_cmd_t  cmd,
  output arlz_pkg::dp_sts_t       sts,
  output arlz_pkg::out_item_t     out_data
);
  import arlz_pkg::*;

  localparam int WIN_DEPTH = 1 << WINDOW_LOG2;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int BUF_AW    = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int MO_W      = WINDOW_LOG2 + 1;
  localparam logic [WINDOW_LOG2-1:0] ONES = '1;
  localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(MAX_BURST);

  logic [7:0] prob_mem [NUM_PROBS];
  logic [7:0] win_mem  [WIN_DEPTH];
  logic [7:0] buf_mem  [MAX_BURST];

  logic [3:0]             win_log2_r;
  logic [CODER_W-1:0]     coder_r, coder_nxt;
  logic [WINDOW_LOG2-1:0] wp_r, wp_nxt;
  logic [MO_W-1:0]        mo_r, mo_nxt;
  logic                   prev_r, prev_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [8:0]             lit_r, lit_nxt;
  logic [30:0]            acc_r, acc_nxt;
  logic [4:0]             pos_r, pos_nxt;
  logic [CTX_W-1:0]       nctx_r, nctx_nxt;
  logic [31:0]            copy_r, copy_nxt;
  logic                   err_r, err_nxt;
  logic [CTX_W-1:0]       clr_idx_r;
  logic [CNT_W-1:0]       n_r, idx_r;
  logic [CTX_W-1:0]       ctx_r;
  logic [7:0]             prob_q_r, win_q_r, buf_q_r;
  logic [2:0]             out_status_r;
  logic                   single_r;

  logic [4:0]             eff;
  logic [WINDOW_LOG2-1:0] mask, wp_m, rd_addr;
  logic [31:0]            limit;
  logic [2:0]             st_code;
  logic [CTX_W-1:0]       ctx_raw, ctx_sel;

  // bit decode
  logic [7:0]  prob, low, prob_new;
  logic [11:0] high;
  logic        b;
  logic [8:0]  mop, inc_p, dec_p;
  logic [20:0] prod;
  logic [21:0] cs_sum;
  logic [31:0] val, off, off_sel;
  logic [8:0]  lit_new;

  logic        emit_en;
  logic [7:0]  emit_val;
  logic [CNT_W-1:0] idx_inc;

  // effective window size
  always_comb begin
    if (win_log2_r < 4'd8) begin
      eff = 5'd8;
    end else if (32'(win_log2_r) > WINDOW_LOG2) begin
      eff = 5'(WINDOW_LOG2);
    end else begin
      eff = {1'b0, win_log2_r};
    end
  end
  assign mask    = ~(ONES << eff);
  assign limit   = 32'd1 << eff;
  assign wp_m    = wp_r & mask;
  assign rd_addr = (wp_m - mo_r[WINDOW_LOG2-1:0]) & mask;

  always_comb begin
    if (err_r) begin
      st_code = STS_ERROR;
    end else if (phase_r == PH_DONE) begin
      st_code = STS_FINISHED;
    end else if ((copy_r != 32'd0) || (|coder_r[19:12])) begin
      st_code = STS_MORE;
    end else begin
      st_code = STS_NEED;
    end
  end

  always_comb begin
    case (phase_r)
      PH_FLAG:                 ctx_raw = CTX_FLAG;
      PH_REP:                  ctx_raw = CTX_REP;
      PH_LIT:                  ctx_raw = {1'b0, lit_r[7:0]};
      PH_OFS_FLAG, PH_LEN_FLAG: ctx_raw = nctx_r;
      PH_OFS_BIT, PH_LEN_BIT:  ctx_raw = nctx_r + 9'd1;
      default:                 ctx_raw = CTX_FLAG;
    endcase
    ctx_sel = (32'(ctx_raw) >= NUM_PROBS) ? CTX_FLAG : ctx_raw;
  end

  assign prob   = prob_q_r;
  assign low    = coder_r[7:0];
  assign high   = coder_r[19:8];
  assign b      = low < prob;
  assign mop    = b ? {1'b0, prob} : (9'd256 - {1'b0, prob});
  assign prod   = 21'(mop) * 21'(high);
  assign cs_sum = {1'b0, prod} + {14'd0, low} - (b ? 22'd0 : {14'd0, prob});
  assign inc_p  = (9'd256 - {1'b0, prob} + 9'd8) >> 4;
  assign dec_p  = ({1'b0, prob} + 9'd8) >> 4;
  assign prob_new = b ? 8'({1'b0, prob} + inc_p) : 8'({1'b0, prob} - dec_p);
  assign val    = {1'b0, acc_r} | (32'd1 << pos_r);
  assign off    = val - 32'd1;
  assign off_sel = (phase_r == PH_REP) ? 32'(mo_r) : off;
  assign lit_new = {lit_r[7:0], b};
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    coder_nxt = coder_r;
    wp_nxt    = wp_r;
    mo_nxt    = mo_r;
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    nctx_nxt  = nctx_r;
    copy_nxt  = copy_r;
    err_nxt   = err_r;
    emit_en   = 1'b0;
    emit_val  = win_q_r;
    if (cmd.shift) begin
      coder_nxt = {coder_r[11:0], in_byte};
    end
    if (cmd.bit_ex) begin
      coder_nxt = cs_sum[CODER_W-1:0];
      case (phase_r)
        PH_FLAG: begin
          if (b) begin
            if (prev_r) begin
              acc_nxt = '0; pos_nxt = '0; nctx_nxt = CTX_OFFSET; phase_nxt = PH_OFS_FLAG;
            end else begin
              phase_nxt = PH_REP;
            end
          end else begin
            lit_nxt   = 9'd1;
            phase_nxt = PH_LIT;
          end
        end
        PH_LIT: begin
          if (lit_new[8]) begin
            emit_en   = 1'b1;
            emit_val  = lit_new[7:0];
            prev_nxt  = 1'b0;
            lit_nxt   = 9'd1;
            phase_nxt = PH_FLAG;
          end else begin
            lit_nxt = lit_new;
          end
        end
        PH_REP, PH_OFS_FLAG, PH_LEN_FLAG: begin
          if ((phase_r == PH_REP) && b) begin
            acc_nxt = '0; pos_nxt = '0; nctx_nxt = CTX_OFFSET; phase_nxt = PH_OFS_FLAG;
          end else if ((phase_r == PH_LEN_FLAG) && !b) begin
            copy_nxt  = val;
            prev_nxt  = 1'b1;
            phase_nxt = PH_FLAG;
          end else if ((phase_r == PH_REP) || !b) begin
            // take the offset: zero ends the stream
            if (off_sel == 32'd0) begin
              phase_nxt = PH_DONE;
            end else if (off_sel > limit) begin
              err_nxt = 1'b1;
            end else begin
              mo_nxt  = off_sel[MO_W-1:0];
              acc_nxt = '0; pos_nxt = '0; nctx_nxt = CTX_LENGTH; phase_nxt = PH_LEN_FLAG;
            end
          end else if (pos_r == 5'd31) begin
            err_nxt = 1'b1;
          end else begin
            phase_nxt = (phase_r == PH_LEN_FLAG) ? PH_LEN_BIT : PH_OFS_BIT;
          end
        end
        PH_OFS_BIT, PH_LEN_BIT: begin
          acc_nxt   = acc_r | (31'(b) << pos_r);
          pos_nxt   = pos_r + 5'd1;
          nctx_nxt  = nctx_r + 9'd2;
          phase_nxt = (phase_r == PH_LEN_BIT) ? PH_LEN_FLAG : PH_OFS_FLAG;
        end
        default: phase_nxt = PH_DONE;
      endcase
    end
    if (cmd.cp_ex) begin
      emit_en  = 1'b1;
      emit_val = win_q_r;
      copy_nxt = copy_r - 32'd1;
    end
    if (emit_en) begin
      wp_nxt = (wp_m + 1'b1) & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_log2_r   <= 4'd15;
      coder_r      <= '0;
      wp_r         <= '0;
      mo_r         <= '0;
      prev_r       <= 1'b0;
      phase_r      <= PH_FLAG;
      lit_r        <= 9'd1;
      acc_r        <= '0;
      pos_r        <= '0;
      nctx_r       <= '0;
      copy_r       <= '0;
      err_r        <= 1'b0;
      clr_idx_r    <= '0;
      n_r          <= '0;
      idx_r        <= '0;
      out_status_r <= STS_NEED;
      single_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        win_log2_r <= cfg_wdata;
      end
      coder_r <= coder_nxt;
      wp_r    <= wp_nxt;
      mo_r    <= mo_nxt;
      prev_r  <= prev_nxt;
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      nctx_r  <= nctx_nxt;
      copy_r  <= copy_nxt;
      err_r   <= err_nxt;
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + 9'd1;
      end
      if (cmd.n_clr) begin
        n_r <= '0;
      end else if (emit_en) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.reject) begin
        out_status_r <= (st_code == STS_MORE) ? STS_REJECTED : st_code;
        single_r     <= 1'b1;
      end
      if (cmd.fin) begin
        out_status_r <= st_code;
        single_r     <= (n_r == '0);
        idx_r        <= '0;
      end else if (cmd.out_adv) begin
        idx_r <= idx_inc;
      end
    end
  end

  // probability memory: clearing sweep after reset, then read-modify-write per bit
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      prob_mem[clr_idx_r] <= PROB_INIT;
    end else if (cmd.bit_ex) begin
      prob_mem[ctx_r] <= prob_new;
    end
    if (cmd.bit_rd) begin
      prob_q_r <= prob_mem[ctx_sel];
      ctx_r    <= ctx_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      win_mem[wp_m] <= emit_val;
    end
    if (cmd.cp_rd) begin
      win_q_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      buf_mem[n_r[BUF_AW-1:0]] <= emit_val;
    end
    if (cmd.fin) begin
      buf_q_r <= buf_mem[0];
    end else if (cmd.out_adv) begin
      buf_q_r <= buf_mem[idx_inc[BUF_AW-1:0]];
    end
  end

  assign sts.clr_last  = (32'(clr_idx_r) == NUM_PROBS - 1);
  assign sts.st_code   = st_code;
  assign sts.stop      = err_r || (phase_r == PH_DONE) || (n_r == BURST_MAX);
  assign sts.copy_pend = (copy_r != 32'd0);
  assign sts.coder_ge  = |coder_r[19:12];
  assign sts.out_last  = single_r || (idx_inc == n_r);

  assign out_data.out_byte   = single_r ? 8'd0 : buf_q_r;
  assign out_data.byte_valid = !single_r;
  assign out_data.last       = sts.out_last;
  assign out_data.status     = out_status_r;

endmodule
`default_nettype wire

// File: hdl/arlz_ctrl.sv
// Controller: sequences clearing, bit decodes, match copies and result emission.
`default_nettype none
module arlz_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  input  wire logic              out_stall,
  input  wire arlz_pkg::dp_sts_t sts,
  output logic                   in_stall,
  output logic                   out_valid,
  output arlz_pkg::dp_cmd_t      cmd
);
  import arlz_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_cmd && (sts.st_code != STS_NEED)) begin
            cmd.reject = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            cmd.shift = !in_cmd;
            cmd.n_clr = 1'b1;
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (sts.stop) begin
          state_nxt = ST_FIN;
        end else if (sts.copy_pend) begin
          state_nxt = ST_CP_RD;
        end else if (!sts.coder_ge) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_BIT_RD;
        end
      end
      ST_BIT_RD: begin
        cmd.bit_rd = 1'b1;
        state_nxt  = ST_BIT_EX;
      end
      ST_BIT_EX: begin
        cmd.bit_ex = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_CP_RD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = ST_CP_EX;
      end
      ST_CP_EX: begin
        cmd.cp_ex = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (sts.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.out_adv = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule
`default_nettype wire

// File: hdl/adaptive_rans_lz_decompressor_top.sv
// Top level of the adaptive range-coded LZ decompressor.
`default_nettype none
// Each input transaction either supplies one packed byte (cmd 0) or asks to
// continue pending output (cmd 1). The block shifts the byte into its 20-bit
// coder state, decodes bits with 385 adaptive probabilities while the state is
// at least 4096, runs the LZ literal/match scheme, and emits up to MAX_BURST
// decompressed bytes per transaction; every result of a transaction carries the
// same status and the final one has last set. A transaction that yields no byte
// returns one result with byte_valid low. After reset the block loads the
// probability table and stalls input meanwhile. One item is worked at a
// time: each decoded bit passes through evaluate, probability memory read,
// and multiply and update; each copied match byte through evaluate, window
// memory read and write; the results follow once the burst is done. A
// transaction also passes through accept, a final evaluate and finish; a
// rejected byte goes from accept straight to its result. Write window_log2
// only while idle. Reading history that was never written yields undefined bytes.
module adaptive_rans_lz_decompressor_top #(
  parameter int WINDOW_LOG2 = 15,
  parameter int MAX_BURST   = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire arlz_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output arlz_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata
);
  import arlz_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: drives the handshake and steps the datapath
  arlz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: coder, memories and the held result transaction
  arlz_dp #(
    .WINDOW_LOG2 (WINDOW_LOG2),
    .MAX_BURST   (MAX_BURST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // never take input while results are still being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // an empty result must close its transaction
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.byte_valid) |-> out_data.last)
    else $error("empty result without last");

  // after the last result the block goes back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> (!out_valid && !in_stall))
    else $error("block not idle after last result");
`endif

endmodule
`default_nettype wire
